FILE: src/tked_pkg.sv
// ----------------------------------------------------------------------------
// tked_pkg: shared types and constants of the terminal key escape decoder
// Holds the item and result structs, the parser phase type and the byte and
// key code constants used by the decoder stages.
// ----------------------------------------------------------------------------
package tked_pkg;

  // Received event, one per request on the input channel.
  typedef struct packed {
    logic       func;       // 1 = read timeout, 0 = byte received
    logic [7:0] data_byte;
  } item_t;

  // Decoded key, valid only when the event completes a key.
  typedef struct packed {
    logic       valid;
    logic [9:0] key_code;
  } result_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ESC    = 2'd1,
    PH_SECOND = 2'd2,
    PH_FINAL  = 2'd3
  } phase_e;

  // Bytes that the parser recognizes.
  localparam logic [7:0] ChEsc    = 8'd27;
  localparam logic [7:0] ChLbrack = 8'h5B;  // '['
  localparam logic [7:0] ChUpperO = 8'h4F;  // 'O'
  localparam logic [7:0] ChTilde  = 8'h7E;  // '~'
  localparam logic [7:0] ChDig0   = 8'h30;  // '0'
  localparam logic [7:0] ChDig3   = 8'h33;  // '3'
  localparam logic [7:0] ChDig5   = 8'h35;  // '5'
  localparam logic [7:0] ChDig6   = 8'h36;  // '6'
  localparam logic [7:0] ChDig9   = 8'h39;  // '9'
  localparam logic [7:0] ChA      = 8'h41;  // 'A'
  localparam logic [7:0] ChB      = 8'h42;  // 'B'
  localparam logic [7:0] ChC      = 8'h43;  // 'C'
  localparam logic [7:0] ChD      = 8'h44;  // 'D'
  localparam logic [7:0] ChF      = 8'h46;  // 'F'
  localparam logic [7:0] ChH      = 8'h48;  // 'H'

  // Key codes reported on the output channel.
  localparam logic [9:0] KeyEsc   = 10'd27;
  localparam logic [9:0] KeyLeft  = 10'd1000;
  localparam logic [9:0] KeyRight = 10'd1001;
  localparam logic [9:0] KeyUp    = 10'd1002;
  localparam logic [9:0] KeyDown  = 10'd1003;
  localparam logic [9:0] KeyDel   = 10'd1004;
  localparam logic [9:0] KeyHome  = 10'd1005;
  localparam logic [9:0] KeyEnd   = 10'd1006;
  localparam logic [9:0] KeyPgUp  = 10'd1007;
  localparam logic [9:0] KeyPgDn  = 10'd1008;

endpackage

FILE: src/tked_in_stage.sv
// ----------------------------------------------------------------------------
// tked_in_stage: input register of the decoder
// Captures one event per accepted request and holds it until the decode
// stage takes it.
// ----------------------------------------------------------------------------
module tked_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tked_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output tked_pkg::item_t item_o
);
  import tked_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The register frees up in the same cycle that the decoder takes it.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/tked_decode.sv
// ----------------------------------------------------------------------------
// tked_decode: escape sequence parser
// Holds the parser phase and the stored sequence bytes and decodes one event
// per enabled cycle into at most one key code.
// ----------------------------------------------------------------------------
module tked_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  tked_pkg::item_t   item_i,
  output tked_pkg::result_t result_o
);
  import tked_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] digit_q, digit_d;
  logic [7:0] b;
  result_t    res;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d = phase_q;
    lead_d  = lead_q;
    digit_d = digit_q;
    res     = '0;
    if (item_i.func) begin
      // A timeout flushes a pending sequence as a lone ESC.
      if (phase_q != PH_IDLE) begin
        res.valid    = 1'b1;
        res.key_code = KeyEsc;
        phase_d      = PH_IDLE;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (b == ChEsc) begin
            phase_d = PH_ESC;
          end else begin
            res.valid    = 1'b1;
            res.key_code = {2'b00, b};
          end
        end
        PH_ESC: begin
          lead_d  = b;
          phase_d = PH_SECOND;
        end
        PH_SECOND: begin
          // Anything unrecognized restarts as if a fresh ESC had arrived.
          phase_d = PH_ESC;
          if (lead_q == ChLbrack) begin
            if (b inside {[ChDig0:ChDig9]}) begin
              digit_d = b;
              phase_d = PH_FINAL;
            end else begin
              case (b)
                ChA: begin res.valid = 1'b1; res.key_code = KeyUp;    end
                ChB: begin res.valid = 1'b1; res.key_code = KeyDown;  end
                ChC: begin res.valid = 1'b1; res.key_code = KeyRight; end
                ChD: begin res.valid = 1'b1; res.key_code = KeyLeft;  end
                ChH: begin res.valid = 1'b1; res.key_code = KeyHome;  end
                ChF: begin res.valid = 1'b1; res.key_code = KeyEnd;   end
                default: begin end
              endcase
            end
          end else if (lead_q == ChUpperO) begin
            case (b)
              ChH:     begin res.valid = 1'b1; res.key_code = KeyHome; end
              ChF:     begin res.valid = 1'b1; res.key_code = KeyEnd;  end
              default: begin end
            endcase
          end
          if (res.valid) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_ESC;
          if (b == ChTilde) begin
            case (digit_q)
              ChDig3:  begin res.valid = 1'b1; res.key_code = KeyDel;  end
              ChDig5:  begin res.valid = 1'b1; res.key_code = KeyPgUp; end
              ChDig6:  begin res.valid = 1'b1; res.key_code = KeyPgDn; end
              default: begin end
            endcase
          end
          if (res.valid) begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lead_q  <= '0;
      digit_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      digit_q <= digit_d;
    end
  end

  assign result_o = res;

`ifndef SYNTHESIS
  a_idle_timeout_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.func && phase_q == PH_IDLE) |-> !result_o.valid)
    else $error("timeout while idle produced a key");

  a_result_ends_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && result_o.valid) |=> phase_q == PH_IDLE)
    else $error("parser not idle after a key was reported");

  a_final_after_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && phase_q != PH_FINAL && phase_d == PH_FINAL) |=>
      (digit_q >= ChDig0 && digit_q <= ChDig9))
    else $error("final phase entered without a stored digit");
`endif

endmodule

FILE: src/tked_out_stage.sv
// ----------------------------------------------------------------------------
// tked_out_stage: result register of the decoder
// Holds one decoded key until the receiver takes it; a new key may load in
// the same cycle that the held one leaves.
// ----------------------------------------------------------------------------
module tked_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tked_pkg::result_t result_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [9:0]        key_code_o
);
  import tked_pkg::*;

  logic       valid_q, valid_d;
  logic [9:0] key_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i && result_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && result_i.valid) begin
      key_q <= result_i.key_code;
    end
  end

  assign valid_o    = valid_q;
  assign key_code_o = key_q;

endmodule

FILE: src/terminal_key_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_core: terminal key escape decoder
// Turns a stream of terminal input events into key codes, resolving the
// common arrow, home, end, delete and page escape sequences.
// ----------------------------------------------------------------------------
// Usage. Each request on the slave channel is one event: tuser says whether
// it is a received byte (0) or a read timeout (1), and tdata carries the byte.
// Each request on the master channel is one key code in the low ten bits of
// tdata: 0 to 255 for a plain byte or a lone ESC, 1000 and up for the soft
// keys. An event yields zero or one key; ESC and the middle bytes of a
// sequence yield nothing until the sequence completes or times out.
// The accepting edge loads the event into the input register; once the result
// register is free, the parser decodes it and the key is loaded into the result
// register, which raises tvalid.
// The parser state updates at the same edge as the decode, so one event is
// accepted every cycle, sustained, while the receiver keeps tready high.
// When the receiver stalls, the held key waits in the result register and no
// further event is decoded. Once the input register holds an event, tready
// stays low until the cycle in which the receiver takes the key.
// Reset clears both valid flags and returns the parser to idle with its
// stored sequence bytes at zero.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] func (1 = timeout)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [9:0] key_code, [15:10] zero
);
  import tked_pkg::*;

  item_t      in_item;
  item_t      held_item;
  logic       held_valid;
  logic       advance;
  logic       out_free;
  result_t    dec_result;
  logic [9:0] key_code;

  assign in_item.func      = s_axis_tuser_i;
  assign in_item.data_byte = s_axis_tdata_i;

  // The held event is decoded once the result register can take a key,
  // even when the event itself yields none.
  assign advance = held_valid && out_free;

  tked_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (advance),
    .item_o  (held_item)
  );

  tked_decode u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (held_item),
    .result_o (dec_result)
  );

  tked_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (dec_result),
    .free_o     (out_free),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .key_code_o (key_code)
  );

  assign m_axis_tdata_o = {6'b000000, key_code};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (held_valid && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a stalled result behind it");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !advance)
    else $error("event decoded while a key was still held");

  a_soft_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (key_code <= 10'd255 ||
      (key_code >= KeyLeft && key_code <= KeyPgDn)))
    else $error("key code outside the defined set");
`endif

endmodule

FILE: bench/tb_terminal_key_escape_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_terminal_key_escape_decoder_core: self-checking bench of the key decoder
// Sends terminal events (bytes and read timeouts) into the decoder and checks
// every key code on the master channel against an in-bench decoder model.
// The run has a short directed part, a back-pressure part and randomized
// escape-sequence traffic, with gaps on both sides of the stream.
// ----------------------------------------------------------------------------
module tb_terminal_key_escape_decoder_core;
  import tked_pkg::*;

  localparam int StallLimit  = 4000;  // cycles without any transfer
  localparam int HoldCycles  = 300;   // long receiver hold-off
  localparam int DrainCycles = 10;    // settle time after the last key

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int items_sent = 0;
  int errors = 0;
  int stall_cnt = 0;

  // Key codes that the decoder still owes, oldest first.
  logic [9:0] pending_keys[$];

  // State of the in-bench decoder.
  phase_e     dec_phase = PH_IDLE;
  logic [7:0] dec_lead  = '0;
  logic [7:0] dec_digit = '0;

  always #1 clk = ~clk;

  terminal_key_escape_decoder_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // Advances the decoder model by one event. Returns 1 when the event
  // completes a key, with the code in key.
  function automatic bit decode_event(input logic is_timeout, input logic [7:0] b,
                                      output logic [9:0] key);
    bit hit;
    hit = 1'b0;
    key = '0;
    if (is_timeout) begin
      // A timeout only matters inside a sequence: it reports the lone ESC.
      if (dec_phase != PH_IDLE) begin
        key = KeyEsc;
        hit = 1'b1;
      end
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (b == ChEsc) begin
            dec_phase = PH_ESC;
          end else begin
            key = {2'b00, b};
            return 1'b1;
          end
        end
        PH_ESC: begin
          // The first byte after ESC is stored without any check.
          dec_lead  = b;
          dec_phase = PH_SECOND;
        end
        PH_SECOND: begin
          // Anything unrecognized falls back to the ESC-seen phase.
          dec_phase = PH_ESC;
          if (dec_lead == ChLbrack) begin
            if (b >= ChDig0 && b <= ChDig9) begin
              dec_digit = b;
              dec_phase = PH_FINAL;
            end else begin
              hit = 1'b1;
              case (b)
                ChA:     key = KeyUp;
                ChB:     key = KeyDown;
                ChC:     key = KeyRight;
                ChD:     key = KeyLeft;
                ChH:     key = KeyHome;
                ChF:     key = KeyEnd;
                default: hit = 1'b0;
              endcase
            end
          end else if (dec_lead == ChUpperO) begin
            if (b == ChH) begin
              key = KeyHome;
              hit = 1'b1;
            end else if (b == ChF) begin
              key = KeyEnd;
              hit = 1'b1;
            end
          end
        end
        default: begin
          dec_phase = PH_ESC;
          if (b == ChTilde) begin
            hit = 1'b1;
            if (dec_digit == ChDig3) key = KeyDel;
            else if (dec_digit == ChDig5) key = KeyPgUp;
            else if (dec_digit == ChDig6) key = KeyPgDn;
            else hit = 1'b0;
          end
        end
      endcase
    end
    if (hit) dec_phase = PH_IDLE;
    return hit;
  endfunction

  // Offers one event on the slave channel and waits for the request to be
  // taken. Called right after a rising edge; the expected key, if any, is
  // queued in the step where the event is accepted.
  task automatic send_event(input logic is_timeout, input logic [7:0] b);
    logic [9:0] key;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= is_timeout;
    s_data  <= b;
    do @(posedge clk); while (!s_ready);
    if (decode_event(is_timeout, b, key)) pending_keys.push_back(key);
    items_sent++;
  endtask

  // Stops offering events until every owed key has been delivered.
  task automatic wait_drain();
    s_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Final byte of an ESC [ letter sequence, now and then an arbitrary one.
  function automatic logic [7:0] pick_csi_letter();
    case ($urandom_range(0, 6))
      0:       return ChA;
      1:       return ChB;
      2:       return ChC;
      3:       return ChD;
      4:       return ChH;
      5:       return ChF;
      default: return rand_byte();
    endcase
  endfunction

  // Digit of an ESC [ n ~ sequence, weighted toward the recognized ones.
  function automatic logic [7:0] pick_csi_digit();
    case ($urandom_range(0, 4))
      0:       return ChDig3;
      1:       return ChDig5;
      2:       return ChDig6;
      default: return 8'($urandom_range(ChDig0, ChDig9));
    endcase
  endfunction

  // One randomly chosen piece of terminal traffic: half of it well-formed escape
  // sequences with random content, the rest plain bytes, timeouts and noise.
  task automatic send_random_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      send_event(1'b0, rand_byte());
    end else if (kind < 42) begin
      send_event(1'b0, ChEsc);
      send_event(1'b0, ChLbrack);
      send_event(1'b0, pick_csi_letter());
    end else if (kind < 62) begin
      send_event(1'b0, ChEsc);
      send_event(1'b0, ChLbrack);
      send_event(1'b0, pick_csi_digit());
      send_event(1'b0, ($urandom_range(0, 7) != 0) ? ChTilde : rand_byte());
    end else if (kind < 72) begin
      send_event(1'b0, ChEsc);
      send_event(1'b0, ChUpperO);
      case ($urandom_range(0, 2))
        0:       send_event(1'b0, ChH);
        1:       send_event(1'b0, ChF);
        default: send_event(1'b0, rand_byte());
      endcase
    end else if (kind < 82) begin
      // Sequence cut short by a read timeout at a random depth.
      send_event(1'b0, ChEsc);
      if ($urandom_range(0, 1)) begin
        send_event(1'b0, ChLbrack);
        if ($urandom_range(0, 1)) send_event(1'b0, pick_csi_digit());
      end
      send_event(1'b1, rand_byte());
    end else if (kind < 88) begin
      send_event(1'b1, rand_byte());
    end else if (kind < 94) begin
      // ESC followed by arbitrary lead and second bytes.
      send_event(1'b0, ChEsc);
      send_event(1'b0, rand_byte());
      send_event(1'b0, rand_byte());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_event(1'($urandom_range(0, 1)), rand_byte());
    end
  endtask

  // Extremes of the byte, several key sequences and the odd cases: timeout
  // while idle, timeout inside a sequence, ESC as the lead byte and an
  // unrecognized sequence that restarts decoding.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_event(1'b0, 8'h00);
    send_event(1'b0, 8'hFF);
    send_event(1'b1, 8'hFF);
    send_event(1'b0, ChEsc);
    send_event(1'b0, ChLbrack);
    send_event(1'b0, ChA);
    send_event(1'b0, ChEsc);
    send_event(1'b0, ChUpperO);
    send_event(1'b0, ChF);
    send_event(1'b0, ChEsc);
    send_event(1'b0, ChLbrack);
    send_event(1'b0, ChDig5);
    send_event(1'b0, ChTilde);
    send_event(1'b0, ChEsc);
    send_event(1'b1, 8'h00);
    // Unknown letter: the next byte is taken as a new lead byte.
    send_event(1'b0, ChEsc);
    send_event(1'b0, ChLbrack);
    send_event(1'b0, 8'h5A);
    send_event(1'b0, ChLbrack);
    send_event(1'b0, ChB);
    send_event(1'b0, ChEsc);
    send_event(1'b0, ChEsc);
    send_event(1'b1, 8'h80);
  endtask

  // The receiver holds off while events keep coming, so the decoder fills up
  // and drops tready until the receiver comes back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len <= HoldCycles;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_random_sequence();
      else send_event(1'b0, rand_byte());
    end
  endtask

  task automatic test_random_traffic(input int spct, input int rpct, input int n_items);
    int stop_at;
    send_idle_pct = spct;
    recv_idle_pct = rpct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_sequence();
  endtask

  // Receiver: checks each delivered key against the oldest owed one and
  // draws tready for the next cycle.
  always @(posedge clk) begin : key_check
    logic [9:0] want;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (pending_keys.size() == 0) begin
          errors++;
          $display("%0t: unexpected key, expected none, actual %0d", $time, m_data);
        end else begin
          want = pending_keys.pop_front();
          if (m_data !== {6'b000000, want}) begin
            errors++;
            $display("%0t: key_code mismatch, expected %0d, actual %0d",
                     $time, want, m_data);
          end
        end
      end
      if (hold_len != 0) begin
        m_ready  <= 1'b0;
        hold_len <= hold_len - 1;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt == StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("tb_terminal_key_escape_decoder_core NOT OK");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random_traffic(17, 76, 630);
    wait_drain();
    test_random_traffic(76, 17, 630);
    wait_drain();
    test_random_traffic(0, 0, 630);
    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_keys.size() == 0) begin
      $display("tb_terminal_key_escape_decoder_core OK");
    end else begin
      $display("tb_terminal_key_escape_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
